/* src/tag_presence_tracker_assert.svh */
// Assertion macros for the tag presence tracker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TAG_PRESENCE_TRACKER_ASSERT_SVH
`define TAG_PRESENCE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define TPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tag presence tracker check failed");
`define TPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tag presence tracker check failed");
`else
`define TPT_ASSERT_NOW(lbl, ante, cons)
`define TPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/tpt_pkg.sv */
// Shared sizes and types of the tag presence tracker.
// No dependencies.
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned STEP_W     = $clog2(TABLE_SIZE);

  typedef logic [ID_BITS-1:0] id_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
    logic commit;
    id_t  key;
  } ctrl_t;

  typedef struct packed {
    logic v;
    id_t  id;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_CLOSE = 3'b100
  } state_e;

endpackage

/* src/tpt_cell.sv */
// One slot of the tracker: current and previous window entry.
// Depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpt_pkg::ctrl_t ctrl_i,
  input  logic          prev_now_v_i,
  input  tpt_pkg::link_t before_next_i,
  output logic          now_v_o,
  output tpt_pkg::link_t before_o,
  output logic          match_o
);

  logic         now_v_q;
  tpt_pkg::id_t now_id_q;
  logic         bf_v_q;
  tpt_pkg::id_t bf_id_q;
  logic         take;

  assign take = ctrl_i.ins_en && !now_v_q && prev_now_v_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_v_q <= 1'b0;
      bf_v_q  <= 1'b0;
    end else if (ctrl_i.commit) begin
      bf_v_q  <= now_v_q;
      now_v_q <= 1'b0;
    end else begin
      if (take) begin
        now_v_q <= 1'b1;
      end
      if (ctrl_i.shift_en) begin
        bf_v_q <= before_next_i.v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      bf_id_q <= now_id_q;
    end else begin
      if (take) begin
        now_id_q <= ctrl_i.key;
      end
      if (ctrl_i.shift_en) begin
        bf_id_q <= before_next_i.id;
      end
    end
  end

  assign now_v_o     = now_v_q;
  assign before_o.v  = bf_v_q;
  assign before_o.id = bf_id_q;
  assign match_o     = now_v_q && (now_id_q == ctrl_i.key);

endmodule

/* src/tag_presence_tracker.sv */
// Tag presence tracker top level: control, output word register, row of cells.
// Depends on tpt_pkg, tpt_cell and tag_presence_tracker_assert.svh.
//
// A tag-seen word: every cell compares the ID at once and the first free slot
// takes it. An end-of-window word is first accepted in ST_IDLE. In ST_SCAN
// the previous-window IDs then shift one slot per cycle toward cell 0 while the
// output side keeps up, and each is checked there against the current set. In
// ST_CLOSE the closing word is emitted and the current set moves into the
// previous one; output stalls hold ST_SCAN and ST_CLOSE. Input is taken only
// while no end-of-window run is in progress.
`timescale 1ns / 1ps
`include "tag_presence_tracker_assert.svh"

module tag_presence_tracker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [tpt_pkg::TAG_W-1:0] tag_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [tpt_pkg::TAG_W-1:0] removed_id_o,
  output logic                     has_id_o,
  output logic                     overflow_o,
  output logic                     last_o
);

  localparam int unsigned N = tpt_pkg::TABLE_SIZE;

  tpt_pkg::state_e state_q, state_d;
  logic [tpt_pkg::STEP_W-1:0] step_q, step_d;
  logic dropped_q, dropped_d;

  logic                      out_valid_q, out_valid_d;
  logic [tpt_pkg::TAG_W-1:0] removed_q, removed_d;
  logic                      has_q, has_d;
  logic                      last_q, last_d;
  logic                      ovf_q, ovf_d;

  tpt_pkg::ctrl_t ctrl;
  tpt_pkg::link_t bf_link [N+1];
  logic [N-1:0]   now_v;
  logic [N-1:0]   match;
  logic [N:0]     prev_v;

  logic in_acc, hit, full, out_free, need_emit, adv;
  logic [tpt_pkg::ID_BITS+tpt_pkg::TAG_W-1:0] tag_ext;
  logic [tpt_pkg::ID_BITS+tpt_pkg::TAG_W-1:0] head_ext;

  assign tag_ext  = {{tpt_pkg::ID_BITS{1'b0}}, tag_id_i};
  assign head_ext = {{tpt_pkg::TAG_W{1'b0}}, bf_link[0].id};

  assign in_ready_o = (state_q == tpt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign hit        = |match;
  assign full       = now_v[N-1];
  assign out_free   = !out_valid_q || out_ready_i;
  assign need_emit  = bf_link[0].v && !hit;
  assign adv        = (state_q == tpt_pkg::ST_SCAN) && (!need_emit || out_free);

  assign bf_link[N] = '0;
  assign prev_v[0]  = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign prev_v[i+1] = now_v[i];
    tpt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_now_v_i (prev_v[i]),
      .before_next_i(bf_link[i+1]),
      .now_v_o      (now_v[i]),
      .before_o     (bf_link[i]),
      .match_o      (match[i])
    );
  end

  always_comb begin
    ctrl.key      = (state_q == tpt_pkg::ST_SCAN) ? bf_link[0].id
                                                  : tag_ext[tpt_pkg::ID_BITS-1:0];
    ctrl.ins_en   = in_acc && !cmd_i && !hit;
    ctrl.shift_en = adv;
    ctrl.commit   = (state_q == tpt_pkg::ST_CLOSE) && out_free;

    state_d     = state_q;
    step_d      = step_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    removed_d   = removed_q;
    has_d       = has_q;
    last_d      = last_q;
    ovf_d       = ovf_q;

    unique case (state_q)
      tpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            state_d = tpt_pkg::ST_SCAN;
            step_d  = '0;
          end else if (!hit && full) begin
            dropped_d = 1'b1;
          end
        end
      end
      tpt_pkg::ST_SCAN: begin
        if (adv) begin
          if (need_emit) begin
            out_valid_d = 1'b1;
            removed_d   = head_ext[tpt_pkg::TAG_W-1:0];
            has_d       = 1'b1;
            last_d      = 1'b0;
            ovf_d       = dropped_q;
          end
          if (step_q == tpt_pkg::STEP_W'(N-1)) begin
            state_d = tpt_pkg::ST_CLOSE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      tpt_pkg::ST_CLOSE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          removed_d   = '0;
          has_d       = 1'b0;
          last_d      = 1'b1;
          ovf_d       = dropped_q;
          state_d     = tpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpt_pkg::ST_IDLE;
      step_q      <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    has_q     <= has_d;
    last_q    <= last_d;
    ovf_q     <= ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign removed_id_o = removed_q;
  assign has_id_o     = has_q;
  assign overflow_o   = ovf_q;
  assign last_o       = last_q;

  `TPT_ASSERT_NOW(a_now_prefix, 1'b1, ((now_v & (now_v + 1'b1)) == '0))
  `TPT_ASSERT_NEXT(a_drop_sticky, dropped_q, dropped_q)
  `TPT_ASSERT_NEXT(a_close_word, ctrl.commit, (out_valid_o && last_o && !has_id_o))

endmodule
